FILE: rtl/assert_macros.svh
// Assertion macros shared by the blit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/blit_pkg.sv
// Shared types, constants and arithmetic for the clipped alpha blit.
package blit_pkg;

    localparam int unsigned SCREEN_WIDTH = 240;
    localparam logic [19:0] SCREEN_W20   = 20'(SCREEN_WIDTH);

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM  = 4'd7;

    localparam logic [15:0] MASK_R = 16'hF800;
    localparam logic [15:0] MASK_G = 16'h07E0;
    localparam logic [15:0] MASK_B = 16'h001F;
    localparam logic [7:0]  OPAQUE = 8'hFF;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic        [7:0]  image_width;
        logic        [7:0]  image_height;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_right;
        logic signed [15:0] clip_bottom;
    } t_cfg;

    // floor((bg8*(255-a) + fg*a) / 255), written as bg8*255 + (fg-bg8)*a
    // and divided by 255 through the (x + x/256 + 1)/256 reciprocal.
    function automatic logic [7:0] blend8(input logic [7:0] bg8,
                                          input logic [7:0] fg,
                                          input logic [7:0] a);
        logic signed [9:0]  diff;
        logic signed [17:0] prod;
        logic        [15:0] base;
        logic signed [17:0] sum;
        logic        [15:0] x;
        logic        [16:0] t;
        diff = $signed({2'b00, fg}) - $signed({2'b00, bg8});
        prod = $signed({{8{diff[9]}}, diff}) * $signed({10'b00_0000_0000, a});
        base = {bg8, 8'h00} - {8'h00, bg8};
        sum  = $signed({2'b00, base}) + prod;
        x    = sum[15:0];
        t    = {1'b0, x} + {9'h000, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

FILE: rtl/blit_cfg.sv
// Configuration register file of the blit.
module blit_cfg
    import blit_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x     <= '0;
            r_cfg.origin_y     <= '0;
            r_cfg.image_width  <= 8'd1;
            r_cfg.image_height <= 8'd1;
            r_cfg.clip_left    <= '0;
            r_cfg.clip_top     <= '0;
            r_cfg.clip_right   <= '0;
            r_cfg.clip_bottom  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ORIGIN_X:     r_cfg.origin_x     <= $signed(i_cfg_data);
                REG_ORIGIN_Y:     r_cfg.origin_y     <= $signed(i_cfg_data);
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[7:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[7:0];
                REG_CLIP_LEFT:    r_cfg.clip_left    <= $signed(i_cfg_data);
                REG_CLIP_TOP:     r_cfg.clip_top     <= $signed(i_cfg_data);
                REG_CLIP_RIGHT:   r_cfg.clip_right   <= $signed(i_cfg_data);
                REG_CLIP_BOTTOM:  r_cfg.clip_bottom  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/blit_scan.sv
// Raster column/row tracker of the blit.
module blit_scan
    import blit_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_cfg       i_cfg,
    output logic [7:0] o_column,
    output logic [7:0] o_row,
    output logic       o_last
);

    logic [7:0] r_column, n_column;
    logic [7:0] r_row, n_row;
    logic [7:0] wmax, hmax;
    logic       col_end, row_end;

    // a size of zero behaves as one
    assign wmax    = (i_cfg.image_width  == 8'd0) ? 8'd0 : i_cfg.image_width  - 8'd1;
    assign hmax    = (i_cfg.image_height == 8'd0) ? 8'd0 : i_cfg.image_height - 8'd1;
    assign col_end = (r_column >= wmax);
    assign row_end = (r_row >= hmax);

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        if (i_step) begin
            if (col_end) begin
                n_column = 8'd0;
                n_row    = row_end ? 8'd0 : r_row + 8'd1;
            end else begin
                n_column = r_column + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

    assign o_column = r_column;
    assign o_row    = r_row;
    assign o_last   = col_end && row_end;

endmodule

FILE: rtl/blit_clip.sv
// Screen position, clip test and framebuffer index of one pixel.
module blit_clip
    import blit_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_alpha,
    output logic        o_write_enable,
    output logic [19:0] o_pixel_index
);

    logic signed [16:0] sx, sy;
    logic               in_clip;
    logic        [19:0] sx20, sy20, lin;

    assign sx = $signed({i_cfg.origin_x[15], i_cfg.origin_x}) + $signed({9'h000, i_column});
    assign sy = $signed({i_cfg.origin_y[15], i_cfg.origin_y}) + $signed({9'h000, i_row});

    assign in_clip = (sx >= $signed({i_cfg.clip_left[15],   i_cfg.clip_left}))
                  && (sx <= $signed({i_cfg.clip_right[15],  i_cfg.clip_right}))
                  && (sy >= $signed({i_cfg.clip_top[15],    i_cfg.clip_top}))
                  && (sy <= $signed({i_cfg.clip_bottom[15], i_cfg.clip_bottom}));

    // modulo 2^20 throughout, so the wrap of a negative index falls out
    assign sx20 = {{3{sx[16]}}, sx};
    assign sy20 = {{3{sy[16]}}, sy};
    assign lin  = 20'(sy20 * SCREEN_W20) + sx20;

    assign o_write_enable = in_clip && (i_alpha != 8'd0);
    assign o_pixel_index  = o_write_enable ? lin : 20'd0;

endmodule

FILE: rtl/blit_blend.sv
// Per-channel alpha blend onto the RGB565 background, packed back to 565.
module blit_blend
    import blit_pkg::*;
(
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_alpha,
    input  logic [15:0] i_background,
    input  logic        i_write_enable,
    output logic [15:0] o_color
);

    logic [15:0] bg_r, bg_g, bg_b;
    logic [7:0]  r8, g8, b8;

    assign bg_r = i_background & MASK_R;
    assign bg_g = i_background & MASK_G;
    assign bg_b = i_background & MASK_B;

    // full alpha gives the source channel exactly, so no separate path
    assign r8 = blend8(bg_r[15:8], i_red,   i_alpha);
    assign g8 = blend8({bg_g[10:5], 2'b00}, i_green, i_alpha);
    assign b8 = blend8({bg_b[4:0], 3'b000}, i_blue,  i_alpha);

    assign o_color = i_write_enable ? {r8[7:3], g8[7:2], b8[7:3]} : 16'h0000;

endmodule

FILE: rtl/bgra_over_rgb565_clipped_blit.sv
// Top level of the clipped BGRA-over-RGB565 alpha blit.
//
//  channel   direction  handshake                 word
//  --------  ---------  ------------------------  -------------------------------------
//  in        input      i_in_valid / o_in_stall   src blue, green, red, alpha, background
//  out       output     o_out_valid / i_out_stall write_enable, pixel_index, color, last
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One word per clock unless the output stalls; path is input then result register.
//  The input register holds the pixel with its column/row; the clip test, index and
//  three blends sit between it and the result register.
//  Reset is synchronous and active low: it empties both registers, zeroes the scan
//  position and loads the register defaults (size 1x1, everything else 0).
//  A stall on the output holds the result word; the input is stalled only once the
//  input register is also full and cannot move on.
`include "assert_macros.svh"

module bgra_over_rgb565_clipped_blit
    import blit_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_src_blue,
    input  logic [7:0]            i_src_green,
    input  logic [7:0]            i_src_red,
    input  logic [7:0]            i_src_alpha,
    input  logic [15:0]           i_background,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_write_enable,
    output logic [19:0]           o_pixel_index,
    output logic [15:0]           o_color,
    output logic                  o_last
);

    t_cfg        cfg;
    logic        in_take;
    logic        s1_move;
    logic        out_free;
    logic [7:0]  scan_col, scan_row;
    logic        scan_last;
    logic        n_we;
    logic [19:0] n_idx;
    logic [15:0] n_color;

    // input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_blue, r_s1_green, r_s1_red, r_s1_alpha;
    logic [15:0] r_s1_bg;
    logic [7:0]  r_s1_col, r_s1_row;
    logic        r_s1_last;

    // result register
    logic        r_out_valid;
    logic        r_out_we;
    logic [19:0] r_out_idx;
    logic [15:0] r_out_color;
    logic        r_out_last;

    // pipeline flow: result slot frees when empty or taken, input slot when it moves on
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    blit_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // position advances as each word is accepted
    blit_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_take),
        .i_cfg    (cfg),
        .o_column (scan_col),
        .o_row    (scan_row),
        .o_last   (scan_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_blue  <= i_src_blue;
            r_s1_green <= i_src_green;
            r_s1_red   <= i_src_red;
            r_s1_alpha <= i_src_alpha;
            r_s1_bg    <= i_background;
            r_s1_col   <= scan_col;
            r_s1_row   <= scan_row;
            r_s1_last  <= scan_last;
        end
    end

    blit_clip u_clip (
        .i_cfg          (cfg),
        .i_column       (r_s1_col),
        .i_row          (r_s1_row),
        .i_alpha        (r_s1_alpha),
        .o_write_enable (n_we),
        .o_pixel_index  (n_idx)
    );

    blit_blend u_blend (
        .i_blue         (r_s1_blue),
        .i_green        (r_s1_green),
        .i_red          (r_s1_red),
        .i_alpha        (r_s1_alpha),
        .i_background   (r_s1_bg),
        .i_write_enable (n_we),
        .o_color        (n_color)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_we    <= n_we;
            r_out_idx   <= n_idx;
            r_out_color <= n_color;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_enable = r_out_we;
    assign o_pixel_index  = r_out_idx;
    assign o_color        = r_out_color;
    assign o_last         = r_out_last;

    // skipped pixels carry a zero index and colour
    `ASSERT_IMP(a_skip_zero, i_clk, i_rst_n, r_out_valid && !r_out_we, (r_out_idx == 20'd0) && (r_out_color == 16'h0000), "skipped word has nonzero payload")
    // a word leaving the input register always lands in the result register
    `ASSERT_NXT(a_s1_lands, i_clk, i_rst_n, s1_move, r_out_valid, "word lost between stages")
    // input only stalls when both registers hold words
    `ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_out_valid && i_out_stall, "input stalled with room")

endmodule

FILE: tb/tb.sv
// Self-checking bench for the clipped BGRA-over-RGB565 blit: table-driven directed words, then random.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blit_pkg::*;

    // Register map: the eight registers sit at 0..7, everything above is unmapped.
    localparam int                   REG_COUNT = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_COUNT);

    localparam int RANDOM_WORDS  = 1525;   // on top of the 25 directed pixels
    localparam int SETTLE_CYCLES = 4;      // pipe is two deep; a little margin
    localparam int PRESSURE_HOLD = 64;     // long output hold to back the pipe up

    // One source pixel as offered on the input channel.
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [15:0] background;
    } pixel_t;

    // One framebuffer word as produced on the output channel.
    typedef struct packed {
        logic        we;
        logic [19:0] index;
        logic [15:0] color;
        logic        last;
    } fb_word_t;

    typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_e;

    // Directed stimulus row: either a register write or a pixel. Pixel rows may
    // carry a hand-written expectation (typed = 1); otherwise the predictor decides.
    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_val;
        logic [7:0]           blue;
        logic [7:0]           green;
        logic [7:0]           red;
        logic [7:0]           alpha;
        logic [15:0]          background;
        logic                 typed;
        logic                 we;
        logic [19:0]          index;
        logic [15:0]          color;
        logic                 last;
    } plan_row_t;

    localparam int PLAN_ROWS = 50;

    // kind, register, value, blue, green, red, alpha, background, typed, we, index, color, last
    plan_row_t plan [PLAN_ROWS] = '{
        // straight out of reset: 1x1 image at 0,0, clip is the single pixel 0,0
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b1, 1'b1, '0, 16'hFFFF, 1'b1},
        '{ROW_PIXEL, '0, '0, 8'h00, 8'h00, 8'h00, 8'hFF, 16'hFFFF, 1'b1, 1'b1, '0, 16'h0000, 1'b1},
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'hFFFF, 1'b1, 1'b0, '0, 16'h0000, 1'b1},
        '{ROW_PIXEL, '0, '0, 8'h00, 8'h00, 8'h00, 8'h01, 16'hFFFF, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 16'h0000, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h0F, 8'h55, 8'hAA, 8'h80, 16'hA5A5, 1'b0, '0, '0, '0, '0},
        // 4x2 image up and left of the screen origin: negative linear index wraps
        '{ROW_CFG, REG_ORIGIN_X,     16'hFFFB, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_ORIGIN_Y,     16'hFFFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_IMAGE_WIDTH,  16'h0004, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 16'h0002, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_LEFT,    16'h8000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_TOP,     16'h8000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_RIGHT,   16'h7FFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_BOTTOM,  16'h7FFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h12, 8'h34, 8'h56, 8'hFF, 16'h0000, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'h00, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h80, 8'h80, 8'h80, 8'h40, 16'hF81F, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'h07E0, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h01, 8'h02, 8'h03, 8'hC0, 16'h001F, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hFE, 8'hFD, 8'hFC, 8'h7F, 16'h8410, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h00, 8'h00, 8'h00, 8'hFF, 16'hFFFF, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'h01, 16'h0000, 1'b0, '0, '0, '0, '0},
        // empty clip left to right, zero size (upper data byte must be dropped)
        '{ROW_CFG, REG_CLIP_LEFT,    16'h0001, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_RIGHT,   16'h0000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_IMAGE_WIDTH,  16'h0000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 16'hFF00, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b1, 1'b0, '0, 16'h0000, 1'b1},
        '{ROW_PIXEL, '0, '0, 8'h00, 8'h00, 8'h00, 8'h80, 16'hFFFF, 1'b1, 1'b0, '0, 16'h0000, 1'b1},
        // empty clip top to bottom
        '{ROW_CFG, REG_CLIP_LEFT,    16'h8000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_RIGHT,   16'h7FFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_TOP,     16'h0002, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_BOTTOM,  16'h0001, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b1, 1'b0, '0, 16'h0000, 1'b1},
        // 3x3 at the right screen edge; the unmapped write must not alias origin_x
        '{ROW_CFG, REG_CLIP_TOP,     16'h8000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_CLIP_BOTTOM,  16'h7FFF, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_ORIGIN_X,     16'h00EF, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_ORIGIN_Y,     16'h0000, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_SPARE,        16'h1234, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_IMAGE_WIDTH,  16'h0003, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 16'h0003, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h33, 8'h66, 8'h99, 8'hFF, 16'h1234, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h10, 8'h20, 8'h30, 8'h00, 16'hABCD, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hAA, 8'hBB, 8'hCC, 8'h55, 16'h5555, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h00, 8'h00, 8'h00, 8'h80, 16'hFFFF, 1'b0, '0, '0, '0, '0},
        // shrink to 2x1 with the scan sitting at column 2, row 1
        '{ROW_CFG, REG_IMAGE_WIDTH,  16'h0002, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 16'h0001, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h11, 8'h22, 8'h33, 8'hFF, 16'h0000, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h44, 8'h55, 8'h66, 8'hA0, 16'hF0F0, 1'b0, '0, '0, '0, '0},
        '{ROW_PIXEL, '0, '0, 8'h77, 8'h88, 8'h99, 8'hFF, 16'h0F0F, 1'b0, '0, '0, '0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_src_blue;
    logic [7:0]            i_src_green;
    logic [7:0]            i_src_red;
    logic [7:0]            i_src_alpha;
    logic [15:0]           i_background;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_write_enable;
    logic [19:0]           o_pixel_index;
    logic [15:0]           o_color;
    logic                  o_last;

    bgra_over_rgb565_clipped_blit DUT (.*);

    // Bench copy of the block: registers plus scan position.
    t_cfg       blit_cfg;
    logic [7:0] scan_col;
    logic [7:0] scan_row;

    fb_word_t   predicted_words [$];
    int         mismatches;
    int         pressure_asked;
    int         pressure_given;
    int         hold_left;

    // starts low so the first rising edge comes after the bench has set up
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Per-channel blend, truncating division by 255.
    function automatic logic [7:0] mix8(int bg8, int fg, int a);
        return 8'((bg8 * (255 - a) + fg * a) / 255);
    endfunction

    function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Works out the framebuffer word for one pixel and steps the scan position.
    function automatic fb_word_t blit_pixel(pixel_t px);
        fb_word_t   w;
        logic [7:0] col_end;
        logic [7:0] row_end;
        int         sx;
        int         sy;
        longint     lin;
        w       = '0;
        // a size of zero behaves as one
        col_end = (blit_cfg.image_width  == 8'd0) ? 8'd0 : blit_cfg.image_width  - 8'd1;
        row_end = (blit_cfg.image_height == 8'd0) ? 8'd0 : blit_cfg.image_height - 8'd1;
        sx      = int'(blit_cfg.origin_x) + int'(scan_col);
        sy      = int'(blit_cfg.origin_y) + int'(scan_row);
        w.we    = (sx >= int'(blit_cfg.clip_left)) && (sx <= int'(blit_cfg.clip_right)) &&
                  (sy >= int'(blit_cfg.clip_top))  && (sy <= int'(blit_cfg.clip_bottom)) &&
                  (px.alpha != 8'd0);
        w.last  = (scan_col >= col_end) && (scan_row >= row_end);
        if (w.we) begin
            lin     = longint'(sy) * longint'(SCREEN_WIDTH) + longint'(sx);
            w.index = lin[19:0];
            if (px.alpha == OPAQUE) begin
                w.color = pack565(px.red, px.green, px.blue);
            end else begin
                // background channels widened to 8 bits with zero fill
                w.color = pack565(mix8({px.background[15:11], 3'b000}, px.red,   px.alpha),
                                  mix8({px.background[10:5],  2'b00},  px.green, px.alpha),
                                  mix8({px.background[4:0],   3'b000}, px.blue,  px.alpha));
            end
        end
        // at or past the end of a line wraps, whatever size was in force before
        if (scan_col >= col_end) begin
            scan_col = 8'd0;
            scan_row = (scan_row >= row_end) ? 8'd0 : scan_row + 8'd1;
        end else begin
            scan_col = scan_col + 8'd1;
        end
        return w;
    endfunction

    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            REG_ORIGIN_X:     blit_cfg.origin_x     = val;
            REG_ORIGIN_Y:     blit_cfg.origin_y     = val;
            REG_IMAGE_WIDTH:  blit_cfg.image_width  = val[7:0];
            REG_IMAGE_HEIGHT: blit_cfg.image_height = val[7:0];
            REG_CLIP_LEFT:    blit_cfg.clip_left    = val;
            REG_CLIP_TOP:     blit_cfg.clip_top     = val;
            REG_CLIP_RIGHT:   blit_cfg.clip_right   = val;
            REG_CLIP_BOTTOM:  blit_cfg.clip_bottom  = val;
            default: ;        // unmapped index: dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Leaves write enable high; the next pixel offer drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        store_reg(idx, val);
    endtask

    // Offers one word, holds it until taken, then queues what it should produce.
    task automatic offer_pixel(pixel_t px, logic typed, fb_word_t typed_word);
        fb_word_t w;
        i_cfg_we     <= 1'b0;
        i_in_valid   <= 1'b1;
        i_src_blue   <= px.blue;
        i_src_green  <= px.green;
        i_src_red    <= px.red;
        i_src_alpha  <= px.alpha;
        i_background <= px.background;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        w = blit_pixel(px);
        predicted_words.push_back(typed ? typed_word : w);
    endtask

    task automatic rest(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Input quiet, every expected word out, pipe given time to empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (predicted_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    function automatic int rim_value();
        case ($urandom_range(0, 2))
            0:       return 32767;
            1:       return -32768;
            default: return 0;
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.blue       = 8'($urandom);
        p.green      = 8'($urandom);
        p.red        = 8'($urandom);
        p.background = 16'($urandom);
        case ($urandom_range(0, 7))
            0, 1:    p.alpha = 8'h00;
            2, 3:    p.alpha = OPAQUE;
            default: p.alpha = 8'($urandom);
        endcase
        return p;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly a small image near the screen with a clip window that cuts into it;
    // now and then extremes, fully random registers, empty clips or odd sizes.
    task automatic apply_random_setting();
        int mode;
        int ox, oy, w, h, cl, ct, cr, cb;
        mode = $urandom_range(0, 9);
        w    = $urandom_range(1, 12);
        h    = $urandom_range(1, 8);
        ox   = $urandom_range(0, 280) - 20;
        oy   = $urandom_range(0, 60) - 10;
        cl   = ox + $urandom_range(0, w + 2) - 2;
        ct   = oy + $urandom_range(0, h + 2) - 2;
        cr   = cl + $urandom_range(0, w + 2);
        cb   = ct + $urandom_range(0, h + 2);
        case (mode)
            0: begin
                ox = rim_value();
                oy = rim_value();
                w  = $urandom_range(1, 255);
                h  = $urandom_range(1, 255);
                cl = -32768;
                ct = -32768;
                cr = 32767;
                cb = 32767;
            end
            1: begin
                ox = $urandom;
                oy = $urandom;
                cl = $urandom;
                ct = $urandom;
                cr = $urandom;
                cb = $urandom;
            end
            2: begin
                if ($urandom_range(0, 1) == 0) cr = cl - $urandom_range(1, 5);
                else                           cb = ct - $urandom_range(1, 5);
            end
            3: begin
                w = ($urandom_range(0, 1) == 0) ? 0 : 255;
                h = ($urandom_range(0, 1) == 0) ? 0 : 255;
            end
            default: ;
        endcase
        write_reg(REG_ORIGIN_X,     16'(ox));
        write_reg(REG_ORIGIN_Y,     16'(oy));
        write_reg(REG_IMAGE_WIDTH,  {8'($urandom), 8'(w)});
        write_reg(REG_IMAGE_HEIGHT, {8'($urandom), 8'(h)});
        write_reg(REG_CLIP_LEFT,    16'(cl));
        write_reg(REG_CLIP_TOP,     16'(ct));
        write_reg(REG_CLIP_RIGHT,   16'(cr));
        write_reg(REG_CLIP_BOTTOM,  16'(cb));
        if ($urandom_range(0, 4) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                      16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall stretches, plus a long hold on request so the
    // pipe fills and pushes back on the input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left = 0;
        end else if (pressure_asked != pressure_given) begin
            pressure_given++;
            i_out_stall <= 1'b1;
            hold_left = PRESSURE_HOLD - 1;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 5);
        end else begin
            i_out_stall <= 1'b1;
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 29)
                                                    : $urandom_range(0, 2);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every word taken off the output against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_words
        fb_word_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (predicted_words.size() == 0) begin
                $error("output word with nothing expected: we=%0b index=%h color=%h last=%0b",
                       o_write_enable, o_pixel_index, o_color, o_last);
                mismatches++;
            end else begin
                want = predicted_words.pop_front();
                if (o_write_enable !== want.we) begin
                    $error("write_enable: expected %0b, got %0b", want.we, o_write_enable);
                    mismatches++;
                end
                if (o_pixel_index !== want.index) begin
                    $error("pixel_index: expected %h, got %h", want.index, o_pixel_index);
                    mismatches++;
                end
                if (o_color !== want.color) begin
                    $error("color: expected %h, got %h", want.color, o_color);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        pixel_t   px;
        fb_word_t typed_word;
        int       sent;
        int       phase;
        int       count;
        logic     burst;

        // bench state matches the block's reset defaults
        blit_cfg              = '0;
        blit_cfg.image_width  = 8'd1;
        blit_cfg.image_height = 8'd1;
        scan_col              = 8'd0;
        scan_row              = 8'd0;
        mismatches            = 0;
        pressure_asked        = 0;
        pressure_given        = 0;
        hold_left             = 0;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= REG_ORIGIN_X;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_src_blue   <= '0;
        i_src_green  <= '0;
        i_src_red    <= '0;
        i_src_alpha  <= '0;
        i_background <= '0;
        i_out_stall  <= 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; a run of register rows is preceded by a full drain
        for (int k = 0; k < PLAN_ROWS; k++) begin
            if (plan[k].kind == ROW_CFG) begin
                if (k == 0 || plan[k-1].kind != ROW_CFG) wait_idle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                px         = '{plan[k].blue, plan[k].green, plan[k].red, plan[k].alpha,
                               plan[k].background};
                typed_word = '{plan[k].we, plan[k].index, plan[k].color, plan[k].last};
                offer_pixel(px, plan[k].typed, typed_word);
            end
        end

        // random phases: new register set, then a batch of pixels; the scan
        // position carries over so size changes land mid-image as well
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            wait_idle();
            apply_random_setting();
            if (phase == 2 || phase == 11) begin
                pressure_asked++;
                burst = 1'b1;
                count = 48;
            end else begin
                burst = ($urandom_range(0, 3) == 0);
                count = $urandom_range(8, 80);
            end
            repeat (count) begin
                offer_pixel(rand_pixel(), 1'b0, '0);
                sent++;
                if (!burst) rest(gap_len());
            end
            phase++;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, well clear of the slowest legal run.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/blit_pkg.sv
rtl/blit_cfg.sv
rtl/blit_scan.sv
rtl/blit_clip.sv
rtl/blit_blend.sv
rtl/bgra_over_rgb565_clipped_blit.sv
tb/tb.sv
